// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; compiled out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// next-cycle implication, checked out of reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- design/bed_pkg.sv -----
// ----------------------------------------------------------------------------
// bed_pkg
// Character constants, the escape table and the result-group type.
// ----------------------------------------------------------------------------
package bed_pkg;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_V      = 8'h76;

    localparam int unsigned MAX_RESULTS = 3;

    // up to three results caused by one input beat
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [1:0]                  count;  // 0..3, 0 when nothing is sent
        logic                        bare;   // single bare end marker
        logic                        eos;    // group closes the string
    } grp_t;

    typedef struct packed {
        logic       known;
        logic [7:0] code;
    } esc_t;

    function automatic esc_t escape_map(input logic [7:0] b);
        esc_t r;
        r.known = 1'b1;
        unique case (b)
            CH_N:      r.code = 8'h0A;
            CH_R:      r.code = 8'h0D;
            CH_T:      r.code = 8'h09;
            CH_F:      r.code = 8'h0C;
            CH_V:      r.code = 8'h0B;
            CH_SPACE:  r.code = CH_SPACE;
            CH_BSLASH: r.code = CH_BSLASH;
            default: begin
                r.known = 1'b0;
                r.code  = b;
            end
        endcase
        return r;
    endfunction

endpackage

// ----- design/bed_decode.sv -----
// ----------------------------------------------------------------------------
// bed_decode
// Input register, decoder state and the single-pass decode of one beat
// into a group of up to three results.
// ----------------------------------------------------------------------------
module bed_decode (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [7:0]    s_in_byte,
    input  logic          s_last_byte,
    input  logic          s_valid,
    output logic          s_ready,
    output bed_pkg::grp_t grp_out,
    output logic          grp_valid,
    input  logic          grp_ready
);
    import bed_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    logic       esc_reg,  esc_next;
    logic [1:0] held_reg, held_next;
    logic       disc_reg, disc_next;

    grp_t       grp;
    logic [1:0] cnt;
    logic       plain;
    esc_t       em;
    logic       xfer;

    assign xfer      = in_valid_reg && grp_ready;
    assign s_ready   = !in_valid_reg || grp_ready;
    assign grp_valid = in_valid_reg;
    assign grp_out   = grp;

    always_comb begin
        grp       = '0;
        cnt       = 2'd0;
        plain     = 1'b0;
        esc_next  = esc_reg;
        held_next = held_reg;
        disc_next = disc_reg;
        em        = escape_map(in_byte_reg);

        if (disc_reg) begin
            // dropping the rest of the string
        end else if (esc_reg) begin
            esc_next = 1'b0;
            if (!em.known) begin
                grp.bytes[cnt] = CH_BSLASH;
                cnt            = cnt + 2'd1;
            end
            grp.bytes[cnt] = em.code;
            cnt            = cnt + 2'd1;
        end else if (held_reg == 2'd1) begin
            if (in_byte_reg == CH_DOLLAR && !in_last_reg) begin
                held_next = 2'd2;
            end else begin
                held_next      = 2'd0;
                grp.bytes[cnt] = CH_SPACE;
                cnt            = cnt + 2'd1;
                plain          = 1'b1;
            end
        end else if (held_reg == 2'd2) begin
            held_next = 2'd0;
            if (in_byte_reg == CH_EQUALS) begin
                disc_next = 1'b1;
            end else begin
                grp.bytes[cnt] = CH_SPACE;
                cnt            = cnt + 2'd1;
                grp.bytes[cnt] = CH_DOLLAR;
                cnt            = cnt + 2'd1;
                plain          = 1'b1;
            end
        end else begin
            held_next = 2'd0;
            plain     = 1'b1;
        end

        if (plain) begin
            if (in_byte_reg == CH_BSLASH && !in_last_reg) begin
                esc_next = 1'b1;
            end else if (in_byte_reg == CH_SPACE && !in_last_reg) begin
                held_next = 2'd1;
            end else begin
                grp.bytes[cnt] = in_byte_reg;
                cnt            = cnt + 2'd1;
            end
        end

        if (in_last_reg) begin
            if (cnt == 2'd0) begin
                grp.bare = 1'b1;
                cnt      = 2'd1;
            end
            grp.eos   = 1'b1;
            esc_next  = 1'b0;
            held_next = 2'd0;
            disc_next = 1'b0;
        end
        grp.count = cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            esc_reg      <= 1'b0;
            held_reg     <= 2'd0;
            disc_reg     <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (xfer) begin
                in_valid_reg <= 1'b0;
            end
            if (xfer) begin
                esc_reg  <= esc_next;
                held_reg <= held_next;
                disc_reg <= disc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_last_byte;
        end
    end

endmodule

// ----- design/bed_serial.sv -----
// ----------------------------------------------------------------------------
// bed_serial
// Result register holding one group; sends its results one beat at a time.
// ----------------------------------------------------------------------------
module bed_serial (
    input  logic          aclk,
    input  logic          aresetn,
    input  bed_pkg::grp_t grp_in,
    input  logic          grp_valid,
    output logic          grp_ready,
    output logic [7:0]    m_out_byte,
    output logic          m_byte_valid,
    output logic          m_end_of_string,
    output logic          m_last_of_run,
    output logic          m_valid,
    input  logic          m_ready
);
    import bed_pkg::*;

    logic       hold_valid_reg;
    grp_t       grp_reg;
    logic [1:0] idx_reg;
    logic       at_last;

    assign at_last   = idx_reg == (grp_reg.count - 2'd1);
    assign grp_ready = !hold_valid_reg || (m_ready && at_last);

    assign m_valid         = hold_valid_reg;
    assign m_out_byte      = grp_reg.bare ? 8'h00 : grp_reg.bytes[idx_reg];
    assign m_byte_valid    = !grp_reg.bare;
    assign m_last_of_run   = at_last;
    assign m_end_of_string = at_last && grp_reg.eos;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
        end else if (grp_ready) begin
            // an empty group (held or swallowed byte) sends nothing
            hold_valid_reg <= grp_valid && (grp_in.count != 2'd0);
            idx_reg        <= 2'd0;
        end else if (m_ready) begin
            // group still has results after this beat
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (grp_ready && grp_valid) begin
            grp_reg <= grp_in;
        end
    end

endmodule

// ----- design/backslash_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// backslash_escape_decoder
// Decodes backslash escapes in a byte stream; up to three result beats per
// input beat.
// ----------------------------------------------------------------------------
// Takes one escaped character per input beat (s_last_byte marks the end of a
// string) and returns decoded characters. Backslash plus n, r, t, f, v, space
// or backslash becomes LF, CR, TAB, FF, VT, space or backslash; any other
// escaped byte comes out as backslash and the byte. The sequence space,
// dollar, equals drops the rest of the string; a held space or space-dollar
// is released when the pattern breaks. Every last input beat yields a
// result with m_end_of_string set, a bare one (m_byte_valid low, byte 0)
// if it produced no character. m_last_of_run marks the final result of each
// input beat. Throughput: an input beat is taken every cycle while m_ready
// is high and each beat yields at most one result; a beat with several
// results holds the result register for one m_ beat each while the input
// register in front absorbs one more beat. An s_ beat goes through the
// input register, then the result register. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module backslash_escape_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic [7:0] s_in_byte,
    input  logic       s_last_byte,
    input  logic       s_valid,
    output logic       s_ready,
    // result channel
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_end_of_string,
    output logic       m_last_of_run,
    output logic       m_valid,
    input  logic       m_ready
);
    import bed_pkg::*;

    grp_t grp;         // decoded group, input register side
    logic grp_valid;
    logic grp_ready;
    logic bare_shape;  // fields a bare marker must carry

    // input register, escape/hold/discard state, decode
    bed_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_in_byte   (s_in_byte),
        .s_last_byte (s_last_byte),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .grp_out     (grp),
        .grp_valid   (grp_valid),
        .grp_ready   (grp_ready)
    );

    // result register, one beat per result
    bed_serial u_serial (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .grp_in          (grp),
        .grp_valid       (grp_valid),
        .grp_ready       (grp_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_end_of_string (m_end_of_string),
        .m_last_of_run   (m_last_of_run),
        .m_valid         (m_valid),
        .m_ready         (m_ready)
    );

    assign bare_shape = m_end_of_string && m_last_of_run && (m_out_byte == 8'h00);

    // a bare marker is always the closing, single result of its string
    `ASSERT_IMP(a_bare_closes, aclk, aresetn, m_valid && !m_byte_valid, bare_shape)
    // end of string is always the last result of its input beat
    `ASSERT_IMP(a_eos_last, aclk, aresetn, m_valid && m_end_of_string, m_last_of_run)
    // a multi-result run goes out without a gap
    `ASSERT_NXT(a_run_cont, aclk, aresetn, m_valid && m_ready && !m_last_of_run, m_valid)

endmodule
